FILE: rtl/jhg_pkg.sv
`default_nettype none
package jhg_pkg;

   localparam int GRID_MAX_DEFAULT = 64;

   localparam int CELL_W  = 25;
   localparam int SIZE_W  = 7;
   localparam int COORD_W = 6;
   localparam int CMD_W   = 2;
   localparam int COUNT_W = 16;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] REG_GRID_SIZE  = 3'd0;
   localparam logic [2:0] REG_FIRE_START = 3'd1;
   localparam logic [2:0] REG_FIRE_END   = 3'd2;
   localparam logic [2:0] REG_FIRE_TEMP  = 3'd3;
   localparam logic [2:0] REG_EDGE_TEMP  = 3'd4;

   localparam logic [SIZE_W-1:0] GRID_SIZE_RESET  = 7'd64;
   localparam logic [SIZE_W-1:0] FIRE_START_RESET = 7'd20;
   localparam logic [SIZE_W-1:0] FIRE_END_RESET   = 7'd44;
   localparam logic [CELL_W-1:0] FIRE_TEMP_RESET  = 25'd19660800;
   localparam logic [CELL_W-1:0] EDGE_TEMP_RESET  = 25'd1310720;

   localparam logic [SIZE_W-1:0] GRID_MIN = 7'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic start;
      logic load_wr;
      logic ns_issue;
      logic we_issue;
      logic flush;
      logic rd_issue;
      logic rd_capture;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             rd_in_range;
      logic             last_cell;
      logic             out_free;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: rtl/jhg_ram.sv
`default_nettype none
module jhg_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a_ff,
   output logic      [WIDTH-1:0]         rd_data_b_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

FILE: rtl/jhg_datapath.sv
`default_nettype none
module jhg_datapath #(
   parameter int GRID_MAX = jhg_pkg::GRID_MAX_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [jhg_pkg::SIZE_W-1:0]    grid_size,
   input  wire logic [jhg_pkg::SIZE_W-1:0]    fire_start_col,
   input  wire logic [jhg_pkg::SIZE_W-1:0]    fire_end_col,
   input  wire logic [jhg_pkg::CELL_W-1:0]    fire_temp,
   input  wire logic [jhg_pkg::CELL_W-1:0]    edge_temp,
   input  wire logic [jhg_pkg::CMD_W-1:0]     req_command,
   input  wire logic [jhg_pkg::COORD_W-1:0]   req_row,
   input  wire logic [jhg_pkg::COORD_W-1:0]   req_col,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [jhg_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic      [jhg_pkg::COUNT_W-1:0]   rsp_sweep_count,
   output logic                               rsp_status,
   input  wire jhg_pkg::ctrl_cmd_type         cmd,
   output jhg_pkg::dp_status_type             status
);

   localparam int DEPTH = GRID_MAX * GRID_MAX;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(GRID_MAX);
   localparam int CMPW  = (CW > jhg_pkg::SIZE_W) ? CW : jhg_pkg::SIZE_W;
   localparam int SUMW  = jhg_pkg::CELL_W + 2;

   logic [jhg_pkg::CMD_W-1:0]   command_ff, command_in;
   logic [jhg_pkg::COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [CW-1:0]               r_ff, r_in, c_ff, c_in;
   logic [AW-1:0]               base_ff, base_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [AW-1:0]               pend_addr_ff, pend_addr_in;
   logic                        pend_edge_ff, pend_edge_in;
   logic [SUMW-1:0]             ns_sum_ff, ns_sum_in;
   logic [jhg_pkg::CELL_W-1:0]  cell_ff, cell_in;
   logic                        cur_ff, cur_in;
   logic [jhg_pkg::COUNT_W-1:0] sweeps_ff, sweeps_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [jhg_pkg::CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [jhg_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_status_ff, rsp_status_in;

   logic [jhg_pkg::SIZE_W-1:0]  n_size, n_m1;
   logic [CMPW-1:0]             r_x, c_x, nm1_x;
   logic                        on_edge, last_cell, in_range, out_free;
   logic [AW-1:0]               addr, rd_addr;
   logic [AW-1:0]               raddr_a, raddr_b, waddr;
   logic [jhg_pkg::CELL_W-1:0]  load_value, wdata, sweep_value;
   logic                        wr_en, we_a, we_b;
   logic [jhg_pkg::CELL_W-1:0]  qa_a, qb_a, qa_b, qb_b, qa, qb;
   logic [SUMW-1:0]             full_sum;

   // clamp grid size to the supported range
   always_comb begin
      if (grid_size < jhg_pkg::GRID_MIN) begin
         n_size = jhg_pkg::GRID_MIN;
      end else if (32'(grid_size) > GRID_MAX) begin
         n_size = jhg_pkg::SIZE_W'(GRID_MAX);
      end else begin
         n_size = grid_size;
      end
   end

   assign n_m1      = n_size - 7'd1;
   assign r_x       = CMPW'(r_ff);
   assign c_x       = CMPW'(c_ff);
   assign nm1_x     = CMPW'(n_m1);
   assign on_edge   = (r_x == '0) || (r_x == nm1_x) || (c_x == '0) || (c_x == nm1_x);
   assign last_cell = (r_x == nm1_x) && (c_x == nm1_x);
   assign in_range  = ({1'b0, row_ff} < n_size) && ({1'b0, col_ff} < n_size);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign addr      = base_ff + AW'(c_ff);
   assign rd_addr   = AW'(32'(row_ff) * 32'(GRID_MAX) + 32'(col_ff));

   always_comb begin
      if (r_x == '0) begin
         if ((c_x >= CMPW'(fire_start_col)) && (c_x < CMPW'(fire_end_col))) begin
            load_value = fire_temp;
         end else begin
            load_value = edge_temp;
         end
      end else if (on_edge) begin
         load_value = edge_temp;
      end else begin
         load_value = '0;
      end
   end

   // read ports: north/south first, then west/east; edge cells read themselves
   always_comb begin
      if (cmd.rd_issue) begin
         raddr_a = rd_addr;
         raddr_b = rd_addr;
      end else if (cmd.we_issue) begin
         raddr_a = on_edge ? addr : addr - AW'(1);
         raddr_b = on_edge ? addr : addr + AW'(1);
      end else begin
         raddr_a = on_edge ? addr : addr - AW'(GRID_MAX);
         raddr_b = on_edge ? addr : addr + AW'(GRID_MAX);
      end
   end

   assign qa = cur_ff ? qa_b : qa_a;
   assign qb = cur_ff ? qb_b : qb_a;

   assign full_sum    = ns_sum_ff + SUMW'(qa) + SUMW'(qb);
   assign sweep_value = pend_edge_ff ? qa : full_sum[SUMW-1:2];

   always_comb begin
      if (cmd.load_wr) begin
         wr_en = 1'b1;
         waddr = addr;
         wdata = load_value;
         we_a  = !cur_ff;
         we_b  = cur_ff;
      end else begin
         wr_en = (cmd.ns_issue || cmd.flush) && pend_valid_ff;
         waddr = pend_addr_ff;
         wdata = sweep_value;
         we_a  = wr_en && cur_ff;
         we_b  = wr_en && !cur_ff;
      end
   end

   jhg_ram #(.WIDTH(jhg_pkg::CELL_W), .DEPTH(DEPTH)) u_store_a (
      .clock        (clock),
      .wr_en        (we_a && wr_en),
      .wr_addr      (waddr),
      .wr_data      (wdata),
      .rd_addr_a    (raddr_a),
      .rd_addr_b    (raddr_b),
      .rd_data_a_ff (qa_a),
      .rd_data_b_ff (qb_a)
   );

   jhg_ram #(.WIDTH(jhg_pkg::CELL_W), .DEPTH(DEPTH)) u_store_b (
      .clock        (clock),
      .wr_en        (we_b && wr_en),
      .wr_addr      (waddr),
      .wr_data      (wdata),
      .rd_addr_a    (raddr_a),
      .rd_addr_b    (raddr_b),
      .rd_data_a_ff (qa_b),
      .rd_data_b_ff (qb_b)
   );

   always_comb begin
      command_in    = command_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      base_in       = base_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      pend_edge_in  = pend_edge_ff;
      ns_sum_in     = ns_sum_ff;
      cell_in       = cell_ff;
      cur_in        = cur_ff;
      sweeps_in     = sweeps_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_cell_in   = rsp_cell_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.start) begin
         command_in    = req_command;
         row_in        = req_row;
         col_in        = req_col;
         r_in          = '0;
         c_in          = '0;
         base_in       = '0;
         pend_valid_in = 1'b0;
      end

      // advance the raster position
      if (cmd.load_wr || cmd.we_issue) begin
         if (c_x == nm1_x) begin
            c_in    = '0;
            r_in    = r_ff + CW'(1);
            base_in = base_ff + AW'(GRID_MAX);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end

      if (cmd.we_issue) begin
         ns_sum_in     = SUMW'(qa) + SUMW'(qb);
         pend_valid_in = 1'b1;
         pend_addr_in  = addr;
         pend_edge_in  = on_edge;
      end

      if (cmd.rd_capture) begin
         cell_in = qa;
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_cell_in   = '0;
         rsp_status_in = 1'b0;
         unique case (command_ff)
            jhg_pkg::CMD_LOAD: begin
               sweeps_in = '0;
            end
            jhg_pkg::CMD_SWEEP: begin
               cur_in = !cur_ff;
               if (sweeps_ff != jhg_pkg::COUNT_MAX) begin
                  sweeps_in = sweeps_ff + 16'd1;
               end
            end
            jhg_pkg::CMD_READ: begin
               if (in_range) begin
                  rsp_cell_in = cell_ff;
               end else begin
                  rsp_status_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         rsp_count_in = sweeps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         cur_ff        <= 1'b0;
         sweeps_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         cur_ff        <= cur_in;
         sweeps_ff     <= sweeps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      command_ff    <= command_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      r_ff          <= r_in;
      c_ff          <= c_in;
      base_ff       <= base_in;
      pend_addr_ff  <= pend_addr_in;
      pend_edge_ff  <= pend_edge_in;
      ns_sum_ff     <= ns_sum_in;
      cell_ff       <= cell_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = rsp_cell_ff;
   assign rsp_sweep_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   assign status.command     = command_ff;
   assign status.rd_in_range = in_range;
   assign status.last_cell   = last_cell;
   assign status.out_free    = out_free;

   a_finish_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result finished while output slot occupied");

   a_write_single_store: assert property (@(posedge clock) disable iff (reset)
      !((we_a && wr_en) && (we_b && wr_en)))
      else $error("both stores written in one cycle");

   a_sweep_toggles_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && command_ff == jhg_pkg::CMD_SWEEP) |=> (cur_ff != $past(cur_ff)))
      else $error("sweep did not swap stores");

endmodule
`default_nettype wire

FILE: rtl/jhg_ctrl.sv
`default_nettype none
module jhg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output jhg_pkg::ctrl_cmd_type       cmd,
   input  wire jhg_pkg::dp_status_type status
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_DISPATCH = 4'd1;
   localparam logic [3:0] ST_LOAD     = 4'd2;
   localparam logic [3:0] ST_SW_NS    = 4'd3;
   localparam logic [3:0] ST_SW_WE    = 4'd4;
   localparam logic [3:0] ST_SW_FLUSH = 4'd5;
   localparam logic [3:0] ST_RD_ISSUE = 4'd6;
   localparam logic [3:0] ST_RD_WAIT  = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.command)
               jhg_pkg::CMD_LOAD:  state_in = ST_LOAD;
               jhg_pkg::CMD_SWEEP: state_in = ST_SW_NS;
               jhg_pkg::CMD_READ:  state_in = status.rd_in_range ? ST_RD_ISSUE : ST_FINISH;
               default:            state_in = ST_FINISH;
            endcase
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            if (status.last_cell) begin
               state_in = ST_FINISH;
            end
         end
         ST_SW_NS: begin
            cmd.ns_issue = 1'b1;
            state_in     = ST_SW_WE;
         end
         ST_SW_WE: begin
            cmd.we_issue = 1'b1;
            state_in     = status.last_cell ? ST_SW_FLUSH : ST_SW_NS;
         end
         ST_SW_FLUSH: begin
            // write the last pending cell
            cmd.flush = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_RD_ISSUE: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_RD_WAIT;
         end
         ST_RD_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.load_wr, cmd.ns_issue, cmd.we_issue,
                cmd.flush, cmd.rd_issue, cmd.rd_capture, cmd.finish}))
      else $error("more than one datapath command at once");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DISPATCH))
      else $error("accepted transaction not dispatched");

   a_sweep_phases: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_NS) |=> (state_ff == ST_SW_WE))
      else $error("sweep phase order broken");

endmodule
`default_nettype wire

FILE: rtl/jacobi_heat_grid_sweep_core.sv
`default_nettype none
// Jacobi heat-grid engine. Command 0 loads the start grid (one cell per cycle),
// command 1 runs one five-point Jacobi sweep between two ping-pong stores
// (the two read ports of the grid store fetch the four neighbors of a cell
// in two steps, north/south then west/east), and command 2 reads one cell. n is
// grid_size clamped to 3..GRID_MAX. One transaction is processed at a time;
// a finished result waits in the output register while the next transaction
// is accepted. Registers sit at byte addresses 4*i on the APB-style port.
module jacobi_heat_grid_sweep_core #(
   parameter int GRID_MAX = jhg_pkg::GRID_MAX_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [jhg_pkg::CMD_W-1:0]     req_command,
   input  wire logic [jhg_pkg::COORD_W-1:0]   req_row,
   input  wire logic [jhg_pkg::COORD_W-1:0]   req_col,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [jhg_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic      [jhg_pkg::COUNT_W-1:0]   rsp_sweep_count,
   output logic                               rsp_status,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [jhg_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [jhg_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [jhg_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [jhg_pkg::SIZE_W-1:0] grid_size_ff, grid_size_in;
   logic [jhg_pkg::SIZE_W-1:0] fire_start_ff, fire_start_in;
   logic [jhg_pkg::SIZE_W-1:0] fire_end_ff, fire_end_in;
   logic [jhg_pkg::CELL_W-1:0] fire_temp_ff, fire_temp_in;
   logic [jhg_pkg::CELL_W-1:0] edge_temp_ff, edge_temp_in;
   logic                       csr_write;
   logic [2:0]                 csr_index;

   jhg_pkg::ctrl_cmd_type  cmd;
   jhg_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      grid_size_in  = grid_size_ff;
      fire_start_in = fire_start_ff;
      fire_end_in   = fire_end_ff;
      fire_temp_in  = fire_temp_ff;
      edge_temp_in  = edge_temp_ff;
      if (csr_write) begin
         unique case (csr_index)
            jhg_pkg::REG_GRID_SIZE:  grid_size_in  = csr_pwdata[jhg_pkg::SIZE_W-1:0];
            jhg_pkg::REG_FIRE_START: fire_start_in = csr_pwdata[jhg_pkg::SIZE_W-1:0];
            jhg_pkg::REG_FIRE_END:   fire_end_in   = csr_pwdata[jhg_pkg::SIZE_W-1:0];
            jhg_pkg::REG_FIRE_TEMP:  fire_temp_in  = csr_pwdata[jhg_pkg::CELL_W-1:0];
            jhg_pkg::REG_EDGE_TEMP:  edge_temp_in  = csr_pwdata[jhg_pkg::CELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         jhg_pkg::REG_GRID_SIZE:  csr_prdata = jhg_pkg::CSR_DW'(grid_size_ff);
         jhg_pkg::REG_FIRE_START: csr_prdata = jhg_pkg::CSR_DW'(fire_start_ff);
         jhg_pkg::REG_FIRE_END:   csr_prdata = jhg_pkg::CSR_DW'(fire_end_ff);
         jhg_pkg::REG_FIRE_TEMP:  csr_prdata = jhg_pkg::CSR_DW'(fire_temp_ff);
         jhg_pkg::REG_EDGE_TEMP:  csr_prdata = jhg_pkg::CSR_DW'(edge_temp_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff  <= jhg_pkg::GRID_SIZE_RESET;
         fire_start_ff <= jhg_pkg::FIRE_START_RESET;
         fire_end_ff   <= jhg_pkg::FIRE_END_RESET;
         fire_temp_ff  <= jhg_pkg::FIRE_TEMP_RESET;
         edge_temp_ff  <= jhg_pkg::EDGE_TEMP_RESET;
      end else begin
         grid_size_ff  <= grid_size_in;
         fire_start_ff <= fire_start_in;
         fire_end_ff   <= fire_end_in;
         fire_temp_ff  <= fire_temp_in;
         edge_temp_ff  <= edge_temp_in;
      end
   end

   jhg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   jhg_datapath #(.GRID_MAX(GRID_MAX)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .grid_size       (grid_size_ff),
      .fire_start_col  (fire_start_ff),
      .fire_end_col    (fire_end_ff),
      .fire_temp       (fire_temp_ff),
      .edge_temp       (edge_temp_ff),
      .req_command     (req_command),
      .req_row         (req_row),
      .req_col         (req_col),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_value  (rsp_cell_value),
      .rsp_sweep_count (rsp_sweep_count),
      .rsp_status      (rsp_status),
      .cmd             (cmd),
      .status          (status)
   );

endmodule
`default_nettype wire
